// ----- rtl/multi_stack_shared_pool_assert.svh -----
// Assertion macros shared by the multi-stack pool RTL
`ifndef MULTI_STACK_SHARED_POOL_ASSERT_SVH
`define MULTI_STACK_SHARED_POOL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/msp_pkg.sv -----
// Types and constants for the multi-stack shared pool
package msp_pkg;

  localparam int DATA_W     = 32;
  localparam int MODE_W     = 2;
  localparam int STACK_ID_W = 2;
  localparam int STATUS_W   = 2;
  localparam int NUM_IDS    = 2 ** STACK_ID_W;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_TOP  = 2'd2
  } msp_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } msp_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } msp_state_e;

  typedef struct packed {
    logic load;    // word taken: capture it and start the store reads
    logic commit;  // read data ready and output slot free: write back
  } msp_cmd_t;

endpackage

// ----- rtl/msp_ctrl.sv -----
// Sequencer for the multi-stack pool: input handshake, write-back timing, output valid
module msp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output msp_pkg::msp_cmd_t cmd_o
);
  import msp_pkg::*;

  msp_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/msp_dpath.sv -----
// Datapath: value and link stores, stack heads, free list head and result registers
module msp_dpath #(
  parameter int POOL_ENTRIES = 64,
  parameter int STACK_COUNT  = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msp_pkg::msp_cmd_t                   cmd_i,
  input  logic [msp_pkg::MODE_W-1:0]          mode_i,
  input  logic [msp_pkg::STACK_ID_W-1:0]      stack_id_i,
  input  logic signed [msp_pkg::DATA_W-1:0]   push_value_i,
  output logic [msp_pkg::STATUS_W-1:0]        status_o,
  output logic signed [msp_pkg::DATA_W-1:0]   top_value_o,
  output logic                                pool_full_o,
  output logic                                stack_empty_o
);
  import msp_pkg::*;

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

  // stores, no reset: links at or above the fill mark read as "next entry"
  logic [LW-1:0]     link_mem  [POOL_ENTRIES];
  logic [DATA_W-1:0] value_mem [POOL_ENTRIES];

  logic [LW-1:0]     heads_q [NUM_IDS];
  logic [LW-1:0]     free_head_q, free_head_d;
  logic [LW-1:0]     fill_q, fill_d;

  logic [MODE_W-1:0]     mode_q;
  logic [STACK_ID_W-1:0] sid_q;
  logic                  sid_ok_q;
  logic [DATA_W-1:0]     val_q;
  logic [LW-1:0]         laddr_q;
  logic [LW-1:0]         link_rdata_q;
  logic [DATA_W-1:0]     value_rdata_q;

  logic [STATUS_W-1:0]   status_q;
  logic [DATA_W-1:0]     top_q;
  logic                  pool_full_q, stack_empty_q;

  // read side, at the accept edge
  logic [LW-1:0] head_in, laddr_in;
  logic [AW-1:0] link_ra, value_ra;

  function automatic logic [AW-1:0] clamp_addr(input logic [LW-1:0] a);
    return (a < NULL_LINK) ? a[AW-1:0] : '0;
  endfunction

  assign head_in  = heads_q[stack_id_i];
  assign laddr_in = (mode_i == MODE_PUSH) ? free_head_q : head_in;
  assign link_ra  = clamp_addr(laddr_in);
  assign value_ra = clamp_addr(head_in);

  // write-back side
  logic [LW-1:0]     head, head_after, hd, link_next, wa, link_wd;
  logic              head_null, free_null, hw, link_we, value_we;
  logic [DATA_W-1:0] value_wd, top_d;
  msp_status_e       status_d;

  assign head      = heads_q[sid_q];
  assign head_null = head >= NULL_LINK;
  assign free_null = free_head_q >= NULL_LINK;
  assign link_next = (laddr_q >= fill_q) ? laddr_q + 1'b1 : link_rdata_q;

  always_comb begin
    status_d    = ST_OK;
    top_d       = '0;
    free_head_d = free_head_q;
    fill_d      = fill_q;
    hw          = 1'b0;
    hd          = head;
    link_we     = 1'b0;
    value_we    = 1'b0;
    wa          = head;
    link_wd     = free_head_q;
    value_wd    = ALL_ONES;
    unique case (mode_q)
      MODE_PUSH: begin
        if (!sid_ok_q || free_null) begin
          status_d = ST_OVERFLOW;
        end else begin
          free_head_d = link_next;
          hw          = 1'b1;
          hd          = free_head_q;
          wa          = free_head_q;
          link_wd     = head;
          value_wd    = val_q;
          link_we     = 1'b1;
          value_we    = 1'b1;
          if (free_head_q == fill_q) fill_d = fill_q + 1'b1;
        end
      end
      MODE_POP: begin
        if (head_null) begin
          status_d = ST_UNDERFLOW;
        end else begin
          hw          = 1'b1;
          hd          = link_next;
          free_head_d = head;
          link_we     = 1'b1;
          value_we    = 1'b1;
        end
      end
      MODE_TOP: begin
        if (head_null) begin
          status_d = ST_UNDERFLOW;
          top_d    = ALL_ONES;
        end else begin
          top_d = value_rdata_q;
        end
      end
      default: ;  // unused mode: no change, flags only
    endcase
  end

  assign head_after = hw ? hd : head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_IDS; i++) heads_q[i] <= NULL_LINK;
      free_head_q <= '0;
      fill_q      <= '0;
    end else if (cmd_i.commit) begin
      if (hw) heads_q[sid_q] <= hd;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q        <= mode_i;
      sid_q         <= stack_id_i;
      sid_ok_q      <= int'(stack_id_i) < STACK_COUNT;
      val_q         <= push_value_i;
      laddr_q       <= laddr_in;
    end
    if (cmd_i.commit) begin
      status_q      <= status_d;
      top_q         <= top_d;
      pool_full_q   <= free_head_d >= NULL_LINK;
      stack_empty_q <= !sid_ok_q || (head_after >= NULL_LINK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) link_rdata_q <= link_mem[link_ra];
    if (cmd_i.commit && link_we) link_mem[wa[AW-1:0]] <= link_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) value_rdata_q <= value_mem[value_ra];
    if (cmd_i.commit && value_we) value_mem[wa[AW-1:0]] <= value_wd;
  end

  assign status_o      = status_q;
  assign top_value_o   = top_q;
  assign pool_full_o   = pool_full_q;
  assign stack_empty_o = stack_empty_q;

endmodule

// ----- rtl/multi_stack_shared_pool.sv -----
// The result is registered at write-back, in the execute state after the word is taken.
// No new word is taken before that write-back, which waits while the output is stalled;
// the execute state waits on the single synchronous read port of each store.
// Reset: stack heads null, free head at entry zero, fill mark zero; stores get no
// clearing pass, links at or above the fill mark read as the in-order free chain.
// Ready for a word once reset is released: the sequencer leaves reset in its idle state.
module multi_stack_shared_pool #(
  parameter int POOL_ENTRIES = 64,
  parameter int STACK_COUNT  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [msp_pkg::MODE_W-1:0]        mode_i,
  input  logic [msp_pkg::STACK_ID_W-1:0]    stack_id_i,
  input  logic signed [msp_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [msp_pkg::STATUS_W-1:0]      status_o,
  output logic signed [msp_pkg::DATA_W-1:0] top_value_o,
  output logic                              pool_full_o,
  output logic                              stack_empty_o
);
  import msp_pkg::*;

  msp_cmd_t cmd;

  msp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  msp_dpath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .STACK_COUNT  (STACK_COUNT)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .stack_id_i    (stack_id_i),
    .push_value_i  (push_value_i),
    .status_o      (status_o),
    .top_value_o   (top_value_o),
    .pool_full_o   (pool_full_o),
    .stack_empty_o (stack_empty_o)
  );

`include "multi_stack_shared_pool_assert.svh"

  // a taken word holds off the next one until write-back
  `MSP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted while busy")
  // write-back always presents a result
  `MSP_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_o, "write-back lost its result")
  // underflow leaves the addressed stack empty
  `MSP_ASSERT_IMPL(a_underflow_empty, out_valid_o && (status_o == ST_UNDERFLOW), stack_empty_o, "underflow on non-empty stack")

endmodule
